@@ hw/rtl/bpg_pkg.sv @@
package bpg_pkg;

    localparam int PHASE_W = 16;
    localparam int LEN_W   = 24;
    localparam int TOT_W   = 26;
    localparam int TANG_W  = 15;
    localparam int ANG_W   = 16;
    localparam int COORD_W = 24;
    localparam int QUO_W   = 16;
    localparam int FRAC_W  = QUO_W + 1;
    localparam int PROD_W  = PHASE_W + TOT_W;
    localparam int BND_W   = LEN_W + 3;
    localparam int REM_W   = LEN_W + QUO_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {QUO_W{1'b0}}};

    // CORDIC datapath
    localparam int GAIN_W  = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam int GAIN_SH = 22;
    localparam int CX_W    = 36;
    localparam int CZ_W    = 34;
    localparam int CS_W    = 28;
    localparam int CS_SH   = 8;
    localparam int PT_W    = 30;

    typedef enum logic [2:0] {
        REG_RADIUS_LARGE    = 3'd0,
        REG_RADIUS_SMALL    = 3'd1,
        REG_CENTER_DISTANCE = 3'd2,
        REG_TANGENT_ANGLE   = 3'd3,
        REG_ARC_LARGE_LEN   = 3'd4,
        REG_STRAIGHT_LEN    = 3'd5,
        REG_ARC_SMALL_LEN   = 3'd6,
        REG_TOTAL_LEN       = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEC_ARC_LARGE = 2'd0,
        SEC_UPPER     = 2'd1,
        SEC_ARC_SMALL = 2'd2,
        SEC_LOWER     = 2'd3
    } t_sec;

    typedef struct packed {
        logic [LEN_W-1:0]  radius_large;
        logic [LEN_W-1:0]  radius_small;
        logic [LEN_W-1:0]  center_distance;
        logic [TANG_W-1:0] tangent_angle;
        logic [LEN_W-1:0]  arc_large_length;
        logic [LEN_W-1:0]  straight_length;
        logic [LEN_W-1:0]  arc_small_length;
        logic [TOT_W-1:0]  total_length;
        logic [BND_W-1:0]  bnd0;
        logic [BND_W-1:0]  bnd1;
        logic [BND_W-1:0]  bnd2;
        logic [BND_W-1:0]  bnd3;
    } t_cfg;

    typedef struct packed {
        t_sec sec;
        logic past;
    } t_div_tag;

    typedef struct packed {
        t_sec              sec;
        logic [FRAC_W-1:0] f;
        logic [ANG_W-1:0]  ang;
    } t_pt_tag;

    // atan(2^-i) in turns * 2^32
    function automatic logic [31:0] atan_turns32(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/bpg_cfg.sv @@
module bpg_cfg import bpg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LEN_W-1:0]  r_radius_large, r_radius_small, r_center_distance;
    logic [TANG_W-1:0] r_tangent_angle;
    logic [LEN_W-1:0]  r_arc_large, r_straight, r_arc_small;
    logic [TOT_W-1:0]  r_total;
    logic [BND_W-1:0]  r_bnd0, r_bnd1, r_bnd2, r_bnd3;
    t_reg_idx          s_idx;
    logic              s_wr;

    assign s_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign s_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_large    <= '0;
            r_radius_small    <= '0;
            r_center_distance <= '0;
            r_tangent_angle   <= '0;
            r_arc_large       <= '0;
            r_straight        <= '0;
            r_arc_small       <= '0;
            r_total           <= '0;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_RADIUS_LARGE:    r_radius_large    <= pwdata[LEN_W-1:0];
                REG_RADIUS_SMALL:    r_radius_small    <= pwdata[LEN_W-1:0];
                REG_CENTER_DISTANCE: r_center_distance <= pwdata[LEN_W-1:0];
                REG_TANGENT_ANGLE:   r_tangent_angle   <= pwdata[TANG_W-1:0];
                REG_ARC_LARGE_LEN:   r_arc_large       <= pwdata[LEN_W-1:0];
                REG_STRAIGHT_LEN:    r_straight        <= pwdata[LEN_W-1:0];
                REG_ARC_SMALL_LEN:   r_arc_small       <= pwdata[LEN_W-1:0];
                REG_TOTAL_LEN:       r_total           <= pwdata[TOT_W-1:0];
                default: ;
            endcase
        end
    end

    // section end points along the path, kept registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd0 <= '0;
            r_bnd1 <= '0;
            r_bnd2 <= '0;
            r_bnd3 <= '0;
        end else begin
            r_bnd0 <= BND_W'(r_arc_large);
            r_bnd1 <= BND_W'(r_arc_large) + BND_W'(r_straight);
            r_bnd2 <= BND_W'(r_arc_large) + BND_W'(r_straight) + BND_W'(r_arc_small);
            r_bnd3 <= BND_W'(r_arc_large) + BND_W'(r_arc_small)
                      + (BND_W'(r_straight) << 1);
        end
    end

    always_comb begin
        prdata = '0;
        unique case (s_idx)
            REG_RADIUS_LARGE:    prdata = DATA_W'(r_radius_large);
            REG_RADIUS_SMALL:    prdata = DATA_W'(r_radius_small);
            REG_CENTER_DISTANCE: prdata = DATA_W'(r_center_distance);
            REG_TANGENT_ANGLE:   prdata = DATA_W'(r_tangent_angle);
            REG_ARC_LARGE_LEN:   prdata = DATA_W'(r_arc_large);
            REG_STRAIGHT_LEN:    prdata = DATA_W'(r_straight);
            REG_ARC_SMALL_LEN:   prdata = DATA_W'(r_arc_small);
            REG_TOTAL_LEN:       prdata = DATA_W'(r_total);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.radius_large     = r_radius_large;
    assign o_cfg.radius_small     = r_radius_small;
    assign o_cfg.center_distance  = r_center_distance;
    assign o_cfg.tangent_angle    = r_tangent_angle;
    assign o_cfg.arc_large_length = r_arc_large;
    assign o_cfg.straight_length  = r_straight;
    assign o_cfg.arc_small_length = r_arc_small;
    assign o_cfg.total_length     = r_total;
    assign o_cfg.bnd0             = r_bnd0;
    assign o_cfg.bnd1             = r_bnd1;
    assign o_cfg.bnd2             = r_bnd2;
    assign o_cfg.bnd3             = r_bnd3;

endmodule

@@ hw/rtl/bpg_div.sv @@
// Restoring divider, one quotient bit per stage.
module bpg_div import bpg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [REM_W-1:0] i_rem,
    input  logic [LEN_W-1:0] i_len,
    input  t_div_tag         i_tag,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo,
    output t_div_tag         o_tag
);

    logic [QUO_W-1:0] r_v;
    logic [REM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [LEN_W-1:0] r_len [QUO_W];
    t_div_tag         r_tag [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int SH = QUO_W - 1 - g;
        logic             s_v;
        logic [REM_W-1:0] s_rem;
        logic [QUO_W-1:0] s_quo;
        logic [LEN_W-1:0] s_len;
        t_div_tag         s_tag;
        logic [REM_W-1:0] s_dvs;
        logic             s_ge;

        if (g == 0) begin : g_src
            assign s_v   = i_valid;
            assign s_rem = i_rem;
            assign s_quo = '0;
            assign s_len = i_len;
            assign s_tag = i_tag;
        end else begin : g_src
            assign s_v   = r_v[g-1];
            assign s_rem = r_rem[g-1];
            assign s_quo = r_quo[g-1];
            assign s_len = r_len[g-1];
            assign s_tag = r_tag[g-1];
        end

        assign s_dvs = REM_W'(s_len) << SH;
        assign s_ge  = (s_rem >= s_dvs);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= s_ge ? (s_rem - s_dvs) : s_rem;
                r_quo[g] <= s_quo | (QUO_W'(s_ge) << SH);
                r_len[g] <= s_len;
                r_tag[g] <= s_tag;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_tag   = r_tag[QUO_W-1];

endmodule

@@ hw/rtl/bpg_cordic.sv @@
// Rotation-mode CORDIC, one micro-rotation per stage, with a registered fold at the input and a registered output.
module bpg_cordic import bpg_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ANG_W-1:0]       i_ang,
    input  logic [LEN_W-1:0]       i_radius,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);

    localparam int GP_W = LEN_W + GAIN_W;

    logic signed [CX_W-1:0] r_x [STEPS+1];
    logic signed [CX_W-1:0] r_y [STEPS+1];
    logic signed [CZ_W-1:0] r_z [STEPS+1];
    logic [STEPS:0]         r_neg;

    logic [GP_W-1:0]        s_gprod;
    logic signed [CX_W-1:0] n_xf, n_yf;

    assign s_gprod = GP_W'(i_radius) * GP_W'(GAIN_Q30);

    // fold into [-1/4, 1/4) turn: negate when in the left half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= $signed(CX_W'(s_gprod[GP_W-1:GAIN_SH]));
            r_y[0]   <= '0;
            r_z[0]   <= $signed({{(CZ_W-ANG_W-QUO_W+1){i_ang[ANG_W-2]}},
                                 i_ang[ANG_W-2:0], {QUO_W{1'b0}}});
            r_neg[0] <= i_ang[ANG_W-1] ^ i_ang[ANG_W-2];
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        logic signed [CX_W-1:0] s_dx, s_dy;
        logic signed [CZ_W-1:0] s_at;

        assign s_dx = r_y[g] >>> g;
        assign s_dy = r_x[g] >>> g;
        assign s_at = $signed(CZ_W'(atan_turns32(g)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CZ_W-1]) begin
                    r_x[g+1] <= r_x[g] - s_dx;
                    r_y[g+1] <= r_y[g] + s_dy;
                    r_z[g+1] <= r_z[g] - s_at;
                end else begin
                    r_x[g+1] <= r_x[g] + s_dx;
                    r_y[g+1] <= r_y[g] - s_dy;
                    r_z[g+1] <= r_z[g] + s_at;
                end
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    assign n_xf = r_neg[STEPS] ? -r_x[STEPS] : r_x[STEPS];
    assign n_yf = r_neg[STEPS] ? -r_y[STEPS] : r_y[STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= CS_W'(n_xf >>> CS_SH);
            o_sin <= CS_W'(n_yf >>> CS_SH);
        end
    end

endmodule

@@ hw/rtl/belt_path_point_generator.sv @@
// Channel   | direction | handshake               | word
// ----------+-----------+-------------------------+------------------------------------
// input     | in        | i_in_valid / o_in_stall | i_phase
// output    | out       | o_out_valid/ i_out_stall| o_pos_x, o_pos_y, o_heading,
//           |           |                         | o_section_index
// config    | in/out    | APB psel/penable/pready | paddr, pwdata, prdata (regs at 4*i)
//
// One word accepted per cycle while the output word is not stalled. Pipeline order:
// multiply, section pick, a 16-stage restoring divider (one quotient bit per stage),
// angle stage, the CORDIC pipeline (CORDIC_STEPS + 2), then three point/output stages.
// Whole pipeline holds on one enable while the output word is stalled; valid bits
// travel with the data so bubbles are harmless. Reset is synchronous, active low,
// and clears the valid bits and the configuration registers.
module belt_path_point_generator import bpg_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input words
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [PHASE_W-1:0]        i_phase,
    // output words
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_pos_x,
    output logic signed [COORD_W-1:0] o_pos_y,
    output logic [ANG_W-1:0]          o_heading,
    output logic [1:0]                o_section_index,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int CMP_W      = BND_W + QUO_W;
    localparam int MUL_W      = PT_W + FRAC_W + 1;
    localparam int SUM_W      = PT_W + 4;

    t_cfg cfg;
    logic adv;

    bpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // global advance: everything moves unless the output word is held
    logic r_out_v;
    assign adv        = !(r_out_v && i_out_stall);
    assign o_in_stall = !adv;

    // ---- stage 1: scale phase by total length (Q26.16)
    logic              r1_v;
    logic [PROD_W-1:0] r1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_prod <= PROD_W'(i_phase) * PROD_W'(cfg.total_length);
        end
    end

    // ---- stage 2: section pick and remainder
    logic [CMP_W-1:0] s_prod;
    logic [BND_W-1:0] s_base;
    logic [LEN_W-1:0] n2_len;
    t_div_tag         n2_tag;
    logic [CMP_W-1:0] s_diff;

    logic             r2_v;
    logic [REM_W-1:0] r2_rem;
    logic [LEN_W-1:0] r2_len;
    t_div_tag         r2_tag;

    assign s_prod = CMP_W'(r1_prod);

    always_comb begin
        n2_tag.past = 1'b0;
        if (s_prod < {cfg.bnd0, {QUO_W{1'b0}}}) begin
            n2_tag.sec = SEC_ARC_LARGE;
            s_base     = '0;
            n2_len     = cfg.arc_large_length;
        end else if (s_prod < {cfg.bnd1, {QUO_W{1'b0}}}) begin
            n2_tag.sec = SEC_UPPER;
            s_base     = cfg.bnd0;
            n2_len     = cfg.straight_length;
        end else if (s_prod < {cfg.bnd2, {QUO_W{1'b0}}}) begin
            n2_tag.sec = SEC_ARC_SMALL;
            s_base     = cfg.bnd1;
            n2_len     = cfg.arc_small_length;
        end else begin
            // lower straight; past the end clamps to its far end
            n2_tag.sec  = SEC_LOWER;
            s_base      = cfg.bnd2;
            n2_len      = cfg.straight_length;
            n2_tag.past = !(s_prod < {cfg.bnd3, {QUO_W{1'b0}}});
        end
    end

    assign s_diff = s_prod - {s_base, {QUO_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_rem <= s_diff[REM_W-1:0];
            r2_len <= n2_len;
            r2_tag <= n2_tag;
        end
    end

    // ---- local fraction: remainder / section length
    logic             d_v;
    logic [QUO_W-1:0] d_quo;
    t_div_tag         d_tag;

    bpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r2_v),
        .i_rem   (r2_rem),
        .i_len   (r2_len),
        .i_tag   (r2_tag),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    // ---- stage A: angle along the arc, heading, radius pick
    logic [ANG_W-1:0]    s_t16, s_t2, s_abase, n_ang;
    logic [FRAC_W-1:0]   s_f, s_m;
    logic [2*FRAC_W-1:0] s_ap;

    logic               rA_v;
    t_pt_tag            rA_tag;
    logic [LEN_W-1:0]   rA_radius;

    assign s_t16  = ANG_W'(cfg.tangent_angle);
    assign s_t2   = {cfg.tangent_angle, 1'b0};
    assign s_f    = d_tag.past ? FRAC_ONE : FRAC_W'(d_quo);
    assign s_m    = (d_tag.sec == SEC_ARC_LARGE) ? (FRAC_ONE - FRAC_W'(s_t2)) : FRAC_W'(s_t2);
    assign s_ap   = (2*FRAC_W)'(s_f) * (2*FRAC_W)'(s_m);
    assign s_abase = (d_tag.sec == SEC_ARC_LARGE) ? (ANG_W'(0) - s_t16) : s_t16;

    always_comb begin
        n_ang = ANG_W'(0) - s_t16;
        case (d_tag.sec)
            SEC_ARC_LARGE: n_ang = s_abase - s_ap[QUO_W+ANG_W-1:QUO_W];
            SEC_UPPER:     n_ang = s_t16;
            SEC_ARC_SMALL: n_ang = s_abase - s_ap[QUO_W+ANG_W-1:QUO_W];
            SEC_LOWER:     n_ang = ANG_W'(0) - s_t16;
            default:       n_ang = ANG_W'(0) - s_t16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
        end else if (adv) begin
            rA_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rA_tag.sec <= d_tag.sec;
            rA_tag.f   <= s_f;
            rA_tag.ang <= n_ang;
            rA_radius  <= (d_tag.sec == SEC_ARC_LARGE) ? cfg.radius_large : cfg.radius_small;
        end
    end

    // ---- CORDIC lanes: arc point plus both tangent points, in lockstep
    logic signed [CS_W-1:0] c_cos, c_sin, tl_cos, tl_sin, ts_cos, ts_sin;

    bpg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_arc (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_ang    (rA_tag.ang),
        .i_radius (rA_radius),
        .o_cos    (c_cos),
        .o_sin    (c_sin)
    );

    bpg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tl (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_ang    (s_t16),
        .i_radius (cfg.radius_large),
        .o_cos    (tl_cos),
        .o_sin    (tl_sin)
    );

    bpg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_ts (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_ang    (s_t16),
        .i_radius (cfg.radius_small),
        .o_cos    (ts_cos),
        .o_sin    (ts_sin)
    );

    logic [CORDIC_LAT-1:0] r_cv;
    t_pt_tag               r_ctag [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (adv) begin
            r_cv <= {r_cv[CORDIC_LAT-2:0], rA_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctag[0] <= rA_tag;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_ctag[k] <= r_ctag[k-1];
            end
        end
    end

    // ---- stage P: tangent end points, lerp deltas and bases, arc point
    t_pt_tag                s_ctag;
    logic signed [PT_W-1:0] s_cd, s_ax, s_ay, s_bx, s_by, s_c, s_s;

    logic                   rP_v;
    t_pt_tag                rP_tag;
    logic signed [PT_W-1:0] rP_dx, rP_dy, rP_basex, rP_basey, rP_arcx, rP_arcy;

    assign s_ctag = r_ctag[CORDIC_LAT-1];
    assign s_cd   = $signed(PT_W'(cfg.center_distance));
    assign s_ax   = PT_W'(tl_cos);
    assign s_ay   = PT_W'(tl_sin);
    assign s_bx   = s_cd + PT_W'(ts_cos);
    assign s_by   = PT_W'(ts_sin);
    assign s_c    = PT_W'(c_cos);
    assign s_s    = PT_W'(c_sin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP_v <= 1'b0;
        end else if (adv) begin
            rP_v <= r_cv[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rP_tag <= s_ctag;
            rP_dy  <= s_by - s_ay;
            if (s_ctag.sec == SEC_LOWER) begin
                // runs from the mirrored small tangent point back to the large one
                rP_dx    <= s_ax - s_bx;
                rP_basex <= s_bx;
                rP_basey <= -s_by;
            end else begin
                rP_dx    <= s_bx - s_ax;
                rP_basex <= s_ax;
                rP_basey <= s_ay;
            end
            rP_arcx <= (s_ctag.sec == SEC_ARC_SMALL) ? (s_cd + s_c) : s_c;
            rP_arcy <= s_s;
        end
    end

    // ---- stage L: lerp products
    logic signed [MUL_W-1:0] s_fs;

    logic                    rL_v;
    t_pt_tag                 rL_tag;
    logic signed [MUL_W-1:0] rL_prodx, rL_prody;
    logic signed [PT_W-1:0]  rL_basex, rL_basey, rL_arcx, rL_arcy;

    assign s_fs = $signed(MUL_W'(rP_tag.f));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rL_v <= 1'b0;
        end else if (adv) begin
            rL_v <= rP_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rL_tag   <= rP_tag;
            rL_prodx <= MUL_W'(rP_dx) * s_fs;
            rL_prody <= MUL_W'(rP_dy) * s_fs;
            rL_basex <= rP_basex;
            rL_basey <= rP_basey;
            rL_arcx  <= rP_arcx;
            rL_arcy  <= rP_arcy;
        end
    end

    // ---- output stage: add, pick, saturate
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COORD_W:0] top;
        logic [COORD_W-1:0]     res;
        top = v[SUM_W-1:COORD_W-1];
        if (top == '0 || top == '1) begin
            res = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic                    s_straight;
    logic signed [SUM_W-1:0] n_px, n_py;

    logic signed [COORD_W-1:0] r_pos_x, r_pos_y;
    logic [ANG_W-1:0]          r_heading;
    t_sec                      r_sec;

    assign s_straight = (rL_tag.sec == SEC_UPPER) || (rL_tag.sec == SEC_LOWER);
    assign n_px = s_straight ? (SUM_W'(rL_basex) + SUM_W'(rL_prodx >>> QUO_W))
                             : SUM_W'(rL_arcx);
    assign n_py = s_straight ? (SUM_W'(rL_basey) + SUM_W'(rL_prody >>> QUO_W))
                             : SUM_W'(rL_arcy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= rL_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos_x   <= $signed(sat_coord(n_px));
            r_pos_y   <= $signed(sat_coord(n_py));
            r_heading <= rL_tag.ang;
            r_sec     <= rL_tag.sec;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_heading       = r_heading;
    assign o_section_index = 2'(r_sec);

endmodule

@@ hw/rtl/bpg_checker.sv @@
module bpg_checker import bpg_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [COORD_W-1:0] o_pos_x,
    input logic signed [COORD_W-1:0] o_pos_y,
    input logic [ANG_W-1:0]          o_heading,
    input logic [1:0]                o_section_index,
    input logic                      pready
);

    // held output word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_heading) && $stable(o_section_index))
        else $error("output word changed while stalled");

    // input is back-pressured exactly when the output word is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output hold");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind belt_path_point_generator bpg_checker u_bpg_checker (.*);
